// File: rtl/core/sorted_index_table_unit_macros.svh
// Assertion macros for the sorted index table unit.
// Depends on a clock named clock and an active-high reset named reset in the using module.
`ifndef SORTED_INDEX_TABLE_UNIT_MACROS_SVH
`define SORTED_INDEX_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT_IMPLY(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("assertion failed");
`define SIT_ASSERT_NEXT(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("assertion failed");
`else
`define SIT_ASSERT_IMPLY(label, cond, cons)
`define SIT_ASSERT_NEXT(label, cond, cons)
`endif
`endif

// File: rtl/core/sit_pkg.sv
// Shared types and codes for the sorted index table unit.
// No dependencies; used by sit_cell and sorted_index_table_unit in rtl/core.
package sit_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_MISSING = 2'd2;

   localparam int KEY_W = 32;
   localparam int REC_W = 31;
   localparam int OUT_W = 9;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_APPLY,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic               compare;
      logic               apply;
      logic               remove;
      logic [KEY_W-1:0]   key;
      logic [REC_W-1:0]   rec;
   } cell_cmd_type;

endpackage

// File: rtl/core/sit_cell.sv
// One slot of the sorted table: holds a key and record, compares and shifts.
// Depends on sit_pkg for the command struct and field widths.
module sit_cell (
   input  logic                          clock,
   input  sit_pkg::cell_cmd_type         cmd,
   input  logic                          occupied,
   input  logic                          left_flag,
   input  logic [sit_pkg::KEY_W-1:0]     left_key,
   input  logic [sit_pkg::REC_W-1:0]     left_rec,
   input  logic [sit_pkg::KEY_W-1:0]     right_key,
   input  logic [sit_pkg::REC_W-1:0]     right_rec,
   output logic [sit_pkg::KEY_W-1:0]     key,
   output logic [sit_pkg::REC_W-1:0]     rec,
   output logic                          flag,
   output logic                          match
);

   logic [sit_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sit_pkg::REC_W-1:0] rec_ff, rec_in;
   logic                      flag_ff, flag_in;
   logic                      match_ff, match_in;
   logic                      le_new, lt_new;

   assign le_new = $signed(key_ff) <= $signed(cmd.key);
   assign lt_new = $signed(key_ff) <  $signed(cmd.key);

   always_comb begin
      flag_in  = flag_ff;
      match_in = match_ff;
      if (cmd.compare) begin
         flag_in  = occupied & (cmd.remove ? lt_new : le_new);
         match_in = occupied & (key_ff == cmd.key);
      end
   end

   always_comb begin
      key_in = key_ff;
      rec_in = rec_ff;
      if (cmd.apply && !flag_ff) begin
         if (cmd.remove) begin
            key_in = right_key;
            rec_in = right_rec;
         end else if (left_flag) begin
            key_in = cmd.key;
            rec_in = cmd.rec;
         end else begin
            key_in = left_key;
            rec_in = left_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      rec_ff   <= rec_in;
      flag_ff  <= flag_in;
      match_ff <= match_in;
   end

   assign key   = key_ff;
   assign rec   = rec_ff;
   assign flag  = flag_ff;
   assign match = match_ff;

endmodule

// File: rtl/core/sit_search.sv
// Binary search over the cells' thermometer flags, one result bit per cycle.
// Depends on nothing but its parameters; the flag row comes from the cells.
module sit_search #(
   parameter int CAPACITY = 256,
   parameter int CNT_W    = 9,
   parameter int IDX_W    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CAPACITY-1:0]  therm,
   output logic [CNT_W-1:0]     pos,
   output logic                 last
);

   localparam int BIT_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;
   localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(CNT_W - 1);
   localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);

   logic               busy_ff, busy_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   cand, cand_m1;
   logic               take;

   assign cand    = pos_ff | ({{(CNT_W-1){1'b0}}, 1'b1} << bit_ff);
   assign cand_m1 = cand - {{(CNT_W-1){1'b0}}, 1'b1};
   assign take    = (cand_m1 < CAP_C) && therm[cand_m1[IDX_W-1:0]];
   assign last    = busy_ff && (bit_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      bit_in  = bit_ff;
      pos_in  = pos_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = TOP_BIT;
         pos_in  = '0;
      end else if (busy_ff) begin
         if (take) pos_in = cand;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff - {{(BIT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bit_ff <= bit_in;
      pos_ff <= pos_in;
   end

   assign pos = pos_ff;

endmodule

// File: rtl/core/sorted_index_table_unit.sv
// Top level of the sorted index table: control, a row of table cells and the search unit.
// Depends on sit_pkg, sit_cell, sit_search and sorted_index_table_unit_macros.svh.
//
//   channel   direction  handshake             words
//   req_      in         req_valid/req_stall   opcode, entry_key, record_number
//   rsp_      out        rsp_valid/rsp_stall   status, position, entry_count
//
// One word at a time: accept, a compare step, a search step per bit of the entry
// count, a shift step, then the result register; a refused insert goes from accept
// straight to the result register. rsp_stall holds the result word until it is taken.
// Reset empties the table.
// req_stall stays high until the result word has been taken.
`include "sorted_index_table_unit_macros.svh"
module sorted_index_table_unit #(
   parameter int CAPACITY = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic signed [sit_pkg::KEY_W-1:0] req_entry_key,
   input  logic [sit_pkg::REC_W-1:0]       req_record_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [sit_pkg::OUT_W-1:0]       rsp_position,
   output logic [sit_pkg::OUT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = {{(CNT_W-1){1'b0}}, 1'b1};

   sit_pkg::state_type            state_ff, state_in;
   logic                          op_ff;
   logic [sit_pkg::KEY_W-1:0]     key_ff;
   logic [sit_pkg::REC_W-1:0]     rec_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [1:0]                    status_ff, status_in;
   logic [CNT_W-1:0]              posn_ff, posn_in;
   logic                          accept, full, found, commit;
   logic                          insert_apply, refused_rsp;
   logic                          search_start, search_last;
   logic [CNT_W-1:0]              search_pos;
   sit_pkg::cell_cmd_type         cmd;
   logic [CAPACITY-1:0]           flag_row, match_row;
   logic [sit_pkg::KEY_W-1:0]     key_row [CAPACITY];
   logic [sit_pkg::REC_W-1:0]     rec_row [CAPACITY];
   logic [CNT_W+sit_pkg::OUT_W-1:0] posn_wide, count_wide;

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == CAP_C);
   assign found  = (search_pos < count_ff) && match_row[search_pos[IDX_W-1:0]];
   assign commit = (op_ff == sit_pkg::OP_INSERT) || found;

   assign insert_apply = (state_ff == sit_pkg::S_APPLY) && (op_ff == sit_pkg::OP_INSERT);
   assign refused_rsp  = rsp_valid && (rsp_status != sit_pkg::STAT_DONE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sit_pkg::S_IDLE: begin
            if (accept) begin
               if (req_opcode == sit_pkg::OP_INSERT && full) state_in = sit_pkg::S_RESPOND;
               else state_in = sit_pkg::S_COMPARE;
            end
         end
         sit_pkg::S_COMPARE: state_in = sit_pkg::S_SEARCH;
         sit_pkg::S_SEARCH: begin
            if (search_last) state_in = sit_pkg::S_APPLY;
         end
         sit_pkg::S_APPLY: state_in = sit_pkg::S_RESPOND;
         sit_pkg::S_RESPOND: begin
            if (!rsp_stall) state_in = sit_pkg::S_IDLE;
         end
         default: state_in = sit_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      search_start = 1'b0;
      cmd.compare  = 1'b0;
      cmd.apply    = 1'b0;
      cmd.remove   = (op_ff == sit_pkg::OP_REMOVE);
      cmd.key      = key_ff;
      cmd.rec      = rec_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      posn_in      = posn_ff;
      case (state_ff)
         sit_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               status_in = sit_pkg::STAT_FULL;
               posn_in   = '0;
            end
         end
         sit_pkg::S_COMPARE: begin
            cmd.compare  = 1'b1;
            search_start = 1'b1;
         end
         sit_pkg::S_SEARCH: begin
         end
         sit_pkg::S_APPLY: begin
            cmd.apply = commit;
            if (commit) begin
               status_in = sit_pkg::STAT_DONE;
               posn_in   = search_pos;
               count_in  = (op_ff == sit_pkg::OP_INSERT) ? count_ff + ONE_C : count_ff - ONE_C;
            end else begin
               status_in = sit_pkg::STAT_MISSING;
               posn_in   = '0;
            end
         end
         sit_pkg::S_RESPOND: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sit_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      status_ff <= status_in;
      posn_ff   <= posn_in;
      if (accept) begin
         op_ff  <= req_opcode;
         key_ff <= req_entry_key;
         rec_ff <= req_record_number;
      end
   end

   assign posn_wide       = {{sit_pkg::OUT_W{1'b0}}, posn_ff};
   assign count_wide      = {{sit_pkg::OUT_W{1'b0}}, count_ff};
   assign rsp_status      = status_ff;
   assign rsp_position    = posn_wide[sit_pkg::OUT_W-1:0];
   assign rsp_entry_count = count_wide[sit_pkg::OUT_W-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      occ;
      logic                      lflag;
      logic [sit_pkg::KEY_W-1:0] lkey, rkey;
      logic [sit_pkg::REC_W-1:0] lrec, rrec;

      assign occ = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_first
         assign lflag = 1'b1;
         assign lkey  = key_ff;
         assign lrec  = rec_ff;
      end else begin : g_mid
         assign lflag = flag_row[i-1];
         assign lkey  = key_row[i-1];
         assign lrec  = rec_row[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rkey = key_row[i];
         assign rrec = rec_row[i];
      end else begin : g_inner
         assign rkey = key_row[i+1];
         assign rrec = rec_row[i+1];
      end

      sit_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occ),
         .left_flag (lflag),
         .left_key  (lkey),
         .left_rec  (lrec),
         .right_key (rkey),
         .right_rec (rrec),
         .key       (key_row[i]),
         .rec       (rec_row[i]),
         .flag      (flag_row[i]),
         .match     (match_row[i])
      );
   end

   sit_search #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_search (
      .clock (clock),
      .reset (reset),
      .start (search_start),
      .therm (flag_row),
      .pos   (search_pos),
      .last  (search_last)
   );

   `SIT_ASSERT_IMPLY(a_count_range, 1'b1, count_ff <= CAP_C)
   `SIT_ASSERT_NEXT(a_busy_after_accept, accept, req_stall)
   `SIT_ASSERT_NEXT(a_insert_grows, insert_apply, count_ff == $past(count_ff) + ONE_C)
   `SIT_ASSERT_IMPLY(a_refused_at_zero, refused_rsp, rsp_position == '0)

endmodule
